// File: design/rswr_pkg.sv
// Shared types and constants for the route stack with revisit check.
// Used by the controller, the datapath and the top level; no dependencies.
package rswr_pkg;

    localparam int OP_W    = 2;
    localparam int POP_W   = 32;
    localparam int COORD_W = 16;
    localparam int QIDX_W  = 7;
    localparam int SCNT_W  = 8;
    localparam int TOT_W   = 39;
    localparam int PAIR_W  = 13;
    localparam int STS_W   = 2;
    localparam int ENTRY_W = POP_W + 2 * COORD_W;

    localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_LAST_RD,
        S_LAST_CAP,
        S_SCAN,
        S_COMMIT,
        S_QRD,
        S_QCAP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic rd_last;
        logic cap_last;
        logic scan_rd;
        logic commit;
        logic rd_query;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_append;
        logic is_remove;
        logic scan_done;
    } t_sts;

endpackage

// File: design/rswr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rswr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/rswr_ctrl.sv
// Controller state machine for the route stack: sequences load, last-stop read,
// scan, commit, query read and result hand-off. Depends on rswr_pkg.
module rswr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_stall,
    input  rswr_pkg::t_sts  i_sts,
    output rswr_pkg::t_cmd  o_cmd,
    output logic            o_stall,
    output logic            o_valid
);

    import rswr_pkg::*;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   out_free;
    t_cmd   cmd;

    assign out_free = !r_out_vld || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_sts.is_append)      n_state = S_SCAN;
                else if (i_sts.is_remove) n_state = S_LAST_RD;
                else                      n_state = S_QRD;
            end
            S_LAST_RD:  n_state = S_LAST_CAP;
            S_LAST_CAP: n_state = S_SCAN;
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_COMMIT;
            end
            S_COMMIT:   n_state = S_QRD;
            S_QRD:      n_state = S_QCAP;
            S_QCAP: begin
                if (out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall  = 1'b0;
                cmd.load = i_valid;
            end
            S_LAST_RD:  cmd.rd_last  = 1'b1;
            S_LAST_CAP: cmd.cap_last = 1'b1;
            S_SCAN:     cmd.scan_rd  = !i_sts.scan_done;
            S_COMMIT:   cmd.commit   = 1'b1;
            S_QRD:      cmd.rd_query = 1'b1;
            S_QCAP:     cmd.out_load = out_free;
            default:    cmd          = '0;
        endcase
    end

    // hold the result until taken; a fresh load replaces a taken one
    assign n_out_vld = cmd.out_load | (r_out_vld & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_cmd   = cmd;
    assign o_valid = r_out_vld;

endmodule

// File: design/rswr_dp.sv
// Datapath for the route stack: stop memory, count, running total, pair
// count, scan compare and result registers. Depends on rswr_pkg, rswr_ram.
module rswr_dp #(
    parameter int DEPTH = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rswr_pkg::t_cmd                i_cmd,
    input  logic [rswr_pkg::OP_W-1:0]     i_op,
    input  logic [rswr_pkg::POP_W-1:0]    i_population,
    input  logic [rswr_pkg::COORD_W-1:0]  i_coord_x,
    input  logic [rswr_pkg::COORD_W-1:0]  i_coord_y,
    input  logic [rswr_pkg::QIDX_W-1:0]   i_query_index,
    output rswr_pkg::t_sts                o_sts,
    output logic [rswr_pkg::SCNT_W-1:0]   o_stop_count,
    output logic [rswr_pkg::TOT_W-1:0]    o_total_population,
    output logic [rswr_pkg::POP_W-1:0]    o_indexed_population,
    output logic                          o_index_valid,
    output logic                          o_revisit_found,
    output logic [rswr_pkg::STS_W-1:0]    o_status
);

    import rswr_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int CW   = (CNTW > QIDX_W) ? CNTW : QIDX_W;
    localparam int HW   = (CNTW > PAIR_W) ? CNTW : PAIR_W;
    localparam int SW   = (CNTW > SCNT_W) ? CNTW : SCNT_W;

    logic [OP_W-1:0]    r_op;
    logic [STS_W-1:0]   r_status, n_status;
    logic [QIDX_W-1:0]  r_qi;
    logic [POP_W-1:0]   r_tgt_pop;
    logic [COORD_W-1:0] r_tgt_x, r_tgt_y;
    logic [CNTW-1:0]    r_count, r_idx, r_hits;
    logic               r_chk;
    logic [TOT_W-1:0]   r_total;
    logic [PAIR_W-1:0]  r_pairs;

    logic [SCNT_W-1:0]  r_o_count;
    logic [TOT_W-1:0]   r_o_total;
    logic [POP_W-1:0]   r_o_ipop;
    logic               r_o_ivld, r_o_rev;
    logic [STS_W-1:0]   r_o_status;

    logic [CNTW-1:0]    cnt_m1, scan_limit;
    logic               cnt_full, cnt_zero, is_append, is_remove, match;
    logic [CW-1:0]      qi_ext;
    logic               q_valid;
    logic [HW-1:0]      hits_ext;
    logic [PAIR_W-1:0]  hits_p;
    logic [SW-1:0]      cnt_ext;

    logic               wr_en, rd_en;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] wr_data, rd_data;
    logic [POP_W-1:0]   rd_pop;
    logic [COORD_W-1:0] rd_x, rd_y;

    assign cnt_m1    = r_count - CNTW'(1);
    assign cnt_full  = (r_count == CNTW'(DEPTH));
    assign cnt_zero  = (r_count == '0);
    assign is_append = (r_op == OP_APPEND) && (r_status == ST_OK);
    assign is_remove = (r_op == OP_REMOVE) && (r_status == ST_OK);
    assign scan_limit = is_append ? r_count : cnt_m1;

    assign rd_pop = rd_data[ENTRY_W-1 -: POP_W];
    assign rd_x   = rd_data[2*COORD_W-1 -: COORD_W];
    assign rd_y   = rd_data[COORD_W-1:0];
    assign match  = (rd_x == r_tgt_x) && (rd_y == r_tgt_y);

    assign qi_ext   = CW'(r_qi);
    assign q_valid  = (qi_ext < CW'(r_count)) && (qi_ext < CW'(DEPTH));
    assign hits_ext = HW'(r_hits);
    assign hits_p   = hits_ext[PAIR_W-1:0];
    assign cnt_ext  = SW'(r_count);

    always_comb begin
        if (i_op == OP_APPEND && cnt_full)      n_status = ST_FULL;
        else if (i_op == OP_REMOVE && cnt_zero) n_status = ST_EMPTY;
        else                                    n_status = ST_OK;
    end

    assign wr_en   = i_cmd.commit && is_append;
    assign wr_data = {r_tgt_pop, r_tgt_x, r_tgt_y};
    assign rd_en   = i_cmd.rd_last | i_cmd.scan_rd | i_cmd.rd_query;

    always_comb begin
        if (i_cmd.rd_last)      rd_addr = cnt_m1[AW-1:0];
        else if (i_cmd.scan_rd) rd_addr = r_idx[AW-1:0];
        else                    rd_addr = qi_ext[AW-1:0];
    end

    rswr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_stops (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_pairs <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_chk <= i_cmd.scan_rd;
            if (i_cmd.commit && is_append) begin
                r_count <= r_count + CNTW'(1);
                r_total <= r_total + TOT_W'(r_tgt_pop);
                r_pairs <= r_pairs + hits_p;
            end else if (i_cmd.commit && is_remove) begin
                r_count <= cnt_m1;
                r_total <= r_total - TOT_W'(r_tgt_pop);
                r_pairs <= r_pairs - hits_p;
            end
        end
    end

    // transaction and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_status  <= n_status;
            r_qi      <= i_query_index;
            r_tgt_pop <= i_population;
            r_tgt_x   <= i_coord_x;
            r_tgt_y   <= i_coord_y;
            r_idx     <= '0;
            r_hits    <= '0;
        end else begin
            if (i_cmd.cap_last) begin
                r_tgt_pop <= rd_pop;
                r_tgt_x   <= rd_x;
                r_tgt_y   <= rd_y;
            end
            if (i_cmd.scan_rd) begin
                r_idx <= r_idx + CNTW'(1);
            end
            // compare data read in the previous cycle
            if (r_chk && match) begin
                r_hits <= r_hits + CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_count  <= cnt_ext[SCNT_W-1:0];
            r_o_total  <= r_total;
            r_o_ipop   <= q_valid ? rd_pop : '0;
            r_o_ivld   <= q_valid;
            r_o_rev    <= (r_pairs != '0);
            r_o_status <= r_status;
        end
    end

    assign o_sts.is_append = is_append;
    assign o_sts.is_remove = is_remove;
    assign o_sts.scan_done = (r_idx == scan_limit);

    assign o_stop_count         = r_o_count;
    assign o_total_population   = r_o_total;
    assign o_indexed_population = r_o_ipop;
    assign o_index_valid        = r_o_ivld;
    assign o_revisit_found      = r_o_rev;
    assign o_status             = r_o_status;

endmodule

// File: design/route_stack_with_revisit_check.sv
// Top level of the route stack with revisit check: controller plus datapath.
// Depends on rswr_pkg, rswr_ctrl, rswr_dp (and rswr_ram through rswr_dp).
//
// Keeps an ordered route of up to DEPTH stops (population, x, y) in a
// single-port-read memory and returns one result per transaction. One
// transaction is processed at a time. A query is dispatched, reads the
// queried stop and captures the result. An append first scans every stored
// stop and then commits; a remove first reads and captures the last stop,
// scans the stops before it and then commits; both then finish as a query.
// The revisit pair count is updated by reading the stored coordinates one
// entry per cycle through the memory's read port. The finished result sits
// in an output register, so the next transaction is taken while the result
// waits. No clearing pass is needed after reset.
module route_stack_with_revisit_check #(
    parameter int DEPTH = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [rswr_pkg::OP_W-1:0]     i_op,
    input  logic [rswr_pkg::POP_W-1:0]    i_population,
    input  logic [rswr_pkg::COORD_W-1:0]  i_coord_x,
    input  logic [rswr_pkg::COORD_W-1:0]  i_coord_y,
    input  logic [rswr_pkg::QIDX_W-1:0]   i_query_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rswr_pkg::SCNT_W-1:0]   o_stop_count,
    output logic [rswr_pkg::TOT_W-1:0]    o_total_population,
    output logic [rswr_pkg::POP_W-1:0]    o_indexed_population,
    output logic                          o_index_valid,
    output logic                          o_revisit_found,
    output logic [rswr_pkg::STS_W-1:0]    o_status
);

    import rswr_pkg::*;

    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int SW   = (CNTW > SCNT_W) ? CNTW : SCNT_W;
    localparam logic [SW-1:0] FULL_EXT = SW'(DEPTH);
    localparam logic [SCNT_W-1:0] FULL_CNT = FULL_EXT[SCNT_W-1:0];

    t_cmd cmd;
    t_sts sts;

    rswr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    rswr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_op                 (i_op),
        .i_population         (i_population),
        .i_coord_x            (i_coord_x),
        .i_coord_y            (i_coord_y),
        .i_query_index        (i_query_index),
        .o_sts                (sts),
        .o_stop_count         (o_stop_count),
        .o_total_population   (o_total_population),
        .o_indexed_population (o_indexed_population),
        .o_index_valid        (o_index_valid),
        .o_revisit_found      (o_revisit_found),
        .o_status             (o_status)
    );

    // a refused append only happens on a full route
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_stop_count == FULL_CNT))
        else $error("append refused while route not full");

    // a refused remove leaves an empty route with nothing summed or paired
    a_empty_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |->
        (o_stop_count == '0 && o_total_population == '0 && !o_revisit_found))
        else $error("empty route reports stops, population or revisit");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_index_valid) |-> (o_indexed_population == '0))
        else $error("out of range index reports nonzero population");

    // one transaction at a time: input is stalled right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second transaction accepted back to back");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for route_stack_with_revisit_check: random and directed stack traffic,
// with a built-in route predictor and scoreboard. Depends on rswr_pkg and the design files.
module tb_top;
    import rswr_pkg::*;

    localparam int DEPTH       = 128;
    localparam int N_ITEMS     = 1950;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_START  = 2000;
    localparam int HOLD_LEN    = 1200;

    // op code 3 is unused by the design and must behave as a query
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [POP_W-1:0]   pop;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [QIDX_W-1:0]  qi;
    } t_stop_req;

    typedef struct packed {
        logic [SCNT_W-1:0] stop_count;
        logic [TOT_W-1:0]  total;
        logic [POP_W-1:0]  idx_pop;
        logic              idx_ok;
        logic              revisit;
        logic [STS_W-1:0]  status;
    } t_route_rsp;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [OP_W-1:0]     i_op = OP_QUERY;
    logic [POP_W-1:0]    i_population = '0;
    logic [COORD_W-1:0]  i_coord_x = '0;
    logic [COORD_W-1:0]  i_coord_y = '0;
    logic [QIDX_W-1:0]   i_query_index = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [SCNT_W-1:0]   o_stop_count;
    logic [TOT_W-1:0]    o_total_population;
    logic [POP_W-1:0]    o_indexed_population;
    logic                o_index_valid;
    logic                o_revisit_found;
    logic [STS_W-1:0]    o_status;

    route_stack_with_revisit_check #(.DEPTH(DEPTH)) i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_op                 (i_op),
        .i_population         (i_population),
        .i_coord_x            (i_coord_x),
        .i_coord_y            (i_coord_y),
        .i_query_index        (i_query_index),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_stop_count         (o_stop_count),
        .o_total_population   (o_total_population),
        .o_indexed_population (o_indexed_population),
        .o_index_valid        (o_index_valid),
        .o_revisit_found      (o_revisit_found),
        .o_status             (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- route predictor
    logic [POP_W-1:0]   route_pop [DEPTH];
    logic [COORD_W-1:0] route_x   [DEPTH];
    logic [COORD_W-1:0] route_y   [DEPTH];
    int unsigned        route_len = 0;
    logic [TOT_W-1:0]   route_total = '0;
    logic [PAIR_W-1:0]  route_pairs = '0;

    int n_append = 0, n_remove = 0, n_query = 0;
    int n_full = 0, n_empty = 0, n_revisit = 0, peak_len = 0;

    function automatic t_route_rsp route_apply(input t_stop_req r);
        t_route_rsp  rsp;
        int unsigned hits;
        int unsigned last;
        hits = 0;
        rsp.status = ST_OK;
        if (r.op == OP_APPEND) begin
            n_append++;
            if (route_len >= DEPTH) begin
                rsp.status = ST_FULL;
                n_full++;
            end else begin
                for (int k = 0; k < route_len; k++)
                    if (route_x[k] == r.x && route_y[k] == r.y) hits++;
                route_pairs = route_pairs + PAIR_W'(hits);
                route_pop[route_len] = r.pop;
                route_x[route_len] = r.x;
                route_y[route_len] = r.y;
                route_len++;
                route_total = route_total + TOT_W'(r.pop);
            end
        end else if (r.op == OP_REMOVE) begin
            n_remove++;
            if (route_len == 0) begin
                rsp.status = ST_EMPTY;
                n_empty++;
            end else begin
                last = route_len - 1;
                for (int k = 0; k < last; k++)
                    if (route_x[k] == route_x[last] && route_y[k] == route_y[last]) hits++;
                route_pairs = route_pairs - PAIR_W'(hits);
                route_total = route_total - TOT_W'(route_pop[last]);
                route_len = last;
            end
        end else begin
            n_query++;
        end
        if (route_len > peak_len) peak_len = route_len;
        rsp.stop_count = SCNT_W'(route_len);
        rsp.total = route_total;
        rsp.idx_ok = (r.qi < route_len);
        rsp.idx_pop = rsp.idx_ok ? route_pop[r.qi] : '0;
        rsp.revisit = (route_pairs != '0);
        if (rsp.revisit) n_revisit++;
        return rsp;
    endfunction

    // ---------------------------------------------------------------- stimulus plan
    t_stop_req  stop_plan_q [$];
    t_route_rsp route_due_q [$];
    int         plan_len = 0;
    int         total_items = 0;

    task automatic add_item(input logic [OP_W-1:0] op, input logic [POP_W-1:0] pop,
                            input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [QIDX_W-1:0] qi);
        t_stop_req r;
        r = '{op: op, pop: pop, x: x, y: y, qi: qi};
        stop_plan_q.push_back(r);
        if (op == OP_APPEND && plan_len < DEPTH) plan_len++;
        if (op == OP_REMOVE && plan_len > 0) plan_len--;
    endtask

    // coordinate styles: 0 full range, 1 tiny pool (many revisits), 2 corners only
    function automatic logic [2*COORD_W-1:0] pick_coord(input int style);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        case (style)
            1: begin
                x = COORD_W'($urandom_range(0, 3));
                y = COORD_W'($urandom_range(0, 3));
            end
            2: begin
                x = $urandom_range(0, 1) ? '1 : '0;
                y = $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
            end
        endcase
        return {x, y};
    endfunction

    function automatic logic [POP_W-1:0] pick_pop(input int style);
        case (style)
            1: return $urandom_range(0, 1) ? '1 : '0;
            2: return $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    // mostly at or below the current length, sometimes right at it, so both sides of the boundary get hit
    function automatic logic [QIDX_W-1:0] pick_index();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 4) v = $urandom_range(0, 127);
        else if (r < 8) v = $urandom_range(0, plan_len);
        else v = (plan_len > 0) ? plan_len - $urandom_range(0, 1) : 0;
        if (v > 127) v = 127;
        return QIDX_W'(v);
    endfunction

    task automatic add_random(input logic [OP_W-1:0] op, input int cstyle, input int pstyle);
        logic [2*COORD_W-1:0] xy;
        xy = pick_coord(cstyle);
        add_item(op, pick_pop(pstyle), xy[2*COORD_W-1:COORD_W], xy[COORD_W-1:0],
                 pick_index());
    endtask

    initial begin
        logic [COORD_W-1:0] fx;
        logic [COORD_W-1:0] fy;
        int kind;
        int cstyle;
        int pstyle;
        int bias;
        int len;
        int r;

        // directed: empty route, corner values, last-stop revisit, refusals
        add_item(OP_QUERY,  32'h0,        16'h0,    16'h0,    7'd0);
        add_item(OP_SPARE,  '1,           '1,       '1,       7'd127);
        add_item(OP_REMOVE, '1,           '1,       '1,       7'd0);
        add_item(OP_APPEND, '1,           '1,       '1,       7'd0);
        add_item(OP_APPEND, '0,           '0,       '0,       7'd1);
        add_item(OP_APPEND, 32'h1,        '1,       '0,       7'd2);
        add_item(OP_APPEND, '1,           '1,       '1,       7'd3);
        add_item(OP_QUERY,  32'h55aa55aa, 16'h1234, 16'h4321, 7'd3);
        add_item(OP_QUERY,  '0,           '0,       '0,       7'd4);
        add_item(OP_QUERY,  '0,           '0,       '0,       7'd127);
        add_item(OP_SPARE,  '0,           '0,       '0,       7'd0);
        add_item(OP_REMOVE, '0,           '0,       '0,       7'd2);
        add_item(OP_APPEND, 32'h12345678, '0,       '1,       7'd3);
        add_item(OP_APPEND, 32'h9abcdef0, '0,       '0,       7'd4);
        repeat (5) add_item(OP_REMOVE, $urandom, COORD_W'($urandom), COORD_W'($urandom), 7'd0);
        add_item(OP_REMOVE, '0,           '0,       '0,       7'd0);
        add_item(OP_QUERY,  '0,           '0,       '0,       7'd0);

        // one full route on a single coordinate with maximum populations
        fx = COORD_W'($urandom);
        fy = COORD_W'($urandom);
        while (plan_len < DEPTH) add_item(OP_APPEND, '1, fx, fy, pick_index());
        add_item(OP_APPEND, '1, fx, fy, 7'd127);
        add_item(OP_QUERY, $urandom, COORD_W'($urandom), COORD_W'($urandom), 7'd127);
        while (plan_len > 0)
            add_item(OP_REMOVE, $urandom, COORD_W'($urandom), COORD_W'($urandom),
                     pick_index());

        while (stop_plan_q.size() < N_ITEMS) begin
            kind = $urandom_range(0, 9);
            cstyle = $urandom_range(0, 2);
            pstyle = $urandom_range(0, 2);
            if (kind < 5) begin
                bias = $urandom_range(0, 2) == 0 ? 80 : ($urandom_range(0, 1) ? 50 : 25);
                len = $urandom_range(20, 80);
                repeat (len) begin
                    r = $urandom_range(0, 99);
                    if (r < 15) add_random(OP_QUERY, cstyle, pstyle);
                    else if (r < 20) add_random(OP_SPARE, cstyle, pstyle);
                    else if ($urandom_range(0, 99) < bias) add_random(OP_APPEND, cstyle, pstyle);
                    else add_random(OP_REMOVE, cstyle, pstyle);
                end
            end else if (kind < 7) begin
                while (plan_len < DEPTH) add_random(OP_APPEND, cstyle, pstyle);
                repeat ($urandom_range(1, 4)) add_random(OP_APPEND, cstyle, pstyle);
            end else if (kind < 9) begin
                while (plan_len > 0) add_random(OP_REMOVE, cstyle, pstyle);
                repeat ($urandom_range(1, 3)) add_random(OP_REMOVE, cstyle, pstyle);
            end else begin
                repeat ($urandom_range(5, 15))
                    add_random($urandom_range(0, 1) ? OP_QUERY : OP_SPARE, cstyle, pstyle);
            end
        end
        total_items = stop_plan_q.size();
    end

    // ---------------------------------------------------------------- idling
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // ---------------------------------------------------------------- driver
    int        accepted_items = 0;
    int        src_gap = 0;
    bit        src_calm = 1'b0;
    t_stop_req offer;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                route_due_q.push_back(route_apply('{op: i_op, pop: i_population, x: i_coord_x,
                                                    y: i_coord_y, qi: i_query_index}));
                accepted_items++;
                if ($urandom_range(0, 63) == 0) src_calm = !src_calm;
            end
            // hold a stalled transaction; otherwise idle or offer the next one
            if (!i_valid || !o_stall) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (stop_plan_q.size() > 0) begin
                    offer = stop_plan_q.pop_front();
                    i_op <= offer.op;
                    i_population <= offer.pop;
                    i_coord_x <= offer.x;
                    i_coord_y <= offer.y;
                    i_query_index <= offer.qi;
                    i_valid <= 1'b1;
                    src_gap = src_calm ? 0 : idle_len();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- long receiver hold-off
    int hold_tick = 0;
    bit sink_hold = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            hold_tick <= hold_tick + 1;
            sink_hold <= (hold_tick >= HOLD_START && hold_tick < HOLD_START + HOLD_LEN);
        end
    end

    // ---------------------------------------------------------------- monitor
    int         fail_count = 0;
    int         sink_gap = 0;
    bit         sink_calm = 1'b0;
    bit         stall_now;
    t_route_rsp due;

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("[%0t] %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (route_due_q.size() == 0) begin
                    $display("[%0t] unexpected result: stop_count %0d, status %0d",
                             $time, o_stop_count, o_status);
                    fail_count++;
                end else begin
                    due = route_due_q.pop_front();
                    check_field("stop_count", due.stop_count, o_stop_count);
                    check_field("total_population", due.total, o_total_population);
                    check_field("indexed_population", due.idx_pop, o_indexed_population);
                    check_field("index_valid", due.idx_ok, o_index_valid);
                    check_field("revisit_found", due.revisit, o_revisit_found);
                    check_field("status", due.status, o_status);
                end
            end
            if ($urandom_range(0, 299) == 0) sink_calm = !sink_calm;
            if (sink_gap == 0 && !sink_calm && $urandom_range(0, 3) == 0)
                sink_gap = idle_len() + 1;
            stall_now = (sink_gap > 0);
            if (sink_gap > 0) sink_gap--;
            i_stall <= sink_hold | stall_now;
        end
    end

    // ---------------------------------------------------------------- watchdog
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles, %0d of %0d accepted, %0d pending",
                     $time, cycle_count, accepted_items, total_items, route_due_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- reset and end of run
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (total_items == 0 || accepted_items < total_items || route_due_q.size() != 0)
            @(posedge i_clk);
        // let a stray late result show up
        repeat (DEPTH + 16) @(posedge i_clk);
        if (route_due_q.size() != 0) begin
            $display("[%0t] %0d results never arrived", $time, route_due_q.size());
            fail_count++;
        end
        $display("Ran %0d transactions: %0d appends (%0d refused full), %0d removes %s",
                 accepted_items, n_append, n_full, n_remove,
                 $sformatf("(%0d refused empty), %0d queries.", n_empty, n_query));
        $display("Route length peaked at %0d of %0d; %0d results flagged a revisit.",
                 peak_len, DEPTH, n_revisit);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
